@@ src/esfbc_pkg.sv @@
// Types, codes and helpers shared by the free block cache modules.
package esfbc_pkg;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	localparam logic [2:0] ACT_HIT    = 3'd0;
	localparam logic [2:0] ACT_FWD    = 3'd1;
	localparam logic [2:0] ACT_ABSORB = 3'd2;
	localparam logic [2:0] ACT_FREE   = 3'd3;
	localparam logic [2:0] ACT_DONE   = 3'd4;

	localparam logic [31:0] THR_RESET = 32'd4194304;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] block_size;
		logic [47:0] block_handle;
	} req_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [47:0] out_handle;
		logic [31:0] out_size;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [31:0] size;
		logic [47:0] handle;
	} entry_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_all;
	} mem_cmd_t;

	function automatic res_t make_res(logic [2:0] act, logic [47:0] h, logic [31:0] s,
			logic lst);
		res_t r;
		r.action     = act;
		r.out_handle = h;
		r.out_size   = s;
		r.last       = lst;
		return r;
	endfunction

endpackage

@@ src/esfbc_mem.sv @@
// Entry table: synchronous memory with registered read data and per-entry valid bits.
module esfbc_mem #(
	parameter int N  = 16,
	parameter int AW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  esfbc_pkg::mem_cmd_t cmd,
	input  logic [AW-1:0]      rd_addr,
	input  logic [AW-1:0]      wr_addr,
	input  esfbc_pkg::entry_t  wr_data,
	output esfbc_pkg::entry_t  rd_data
);

	esfbc_pkg::entry_t mem_q [N];
	logic [N-1:0]      valid_q;
	esfbc_pkg::entry_t rdata_s1;
	logic              rvalid_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (cmd.clr_all) begin
				valid_q <= '0;
			end else if (cmd.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rvalid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_s1 ? rdata_s1 : '0;

endmodule

@@ src/esfbc_ctrl.sv @@
// Request sequencer: scans the table, updates entries and drives results.
module esfbc_ctrl #(
	parameter int N  = 16,
	parameter int AW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  esfbc_pkg::req_t     req,
	input  logic [31:0]         thr,
	output logic                busy,
	output logic                res_strobe,
	output esfbc_pkg::res_t     res,
	output esfbc_pkg::mem_cmd_t cmd,
	output logic [AW-1:0]       rd_addr,
	output logic [AW-1:0]       wr_addr,
	output esfbc_pkg::entry_t   wr_data,
	input  esfbc_pkg::entry_t   rd_data
);

	localparam int CW = $clog2(N + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FDONE = 3'b100
	} state_t;

	state_t            state_q, state_d;
	esfbc_pkg::req_t   req_q;
	logic [CW-1:0]     iss_q, iss_d;
	logic              ev_s1;
	logic [AW-1:0]     ptr_s1;
	logic              emp_vld_q, emp_vld_d;
	logic [AW-1:0]     emp_idx_q, emp_idx_d;
	logic              res_vld_d;
	esfbc_pkg::res_t   res_d;
	logic              ld;
	logic              last_ent;

	always_comb begin
		state_d   = state_q;
		iss_d     = iss_q;
		emp_vld_d = emp_vld_q;
		emp_idx_d = emp_idx_q;
		cmd       = '0;
		rd_addr   = iss_q[AW-1:0];
		wr_addr   = ptr_s1;
		wr_data   = '0;
		res_vld_d = 1'b0;
		res_d     = '0;
		ld        = 1'b0;
		last_ent  = (ptr_s1 == AW'(N - 1));
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ld    = 1'b1;
					iss_d = '0;
					case (req.req_type)
						esfbc_pkg::REQ_ALLOC: begin
							if (req.block_size != 32'd0 && req.block_size <= thr) begin
								state_d = ST_SCAN;
							end else begin
								res_vld_d = 1'b1;
								res_d = esfbc_pkg::make_res(esfbc_pkg::ACT_FWD, 48'd0,
									req.block_size, 1'b1);
							end
						end
						esfbc_pkg::REQ_FREE: begin
							if (req.block_handle == 48'd0 || req.block_size == 32'd0 ||
									req.block_size >= thr) begin
								res_vld_d = 1'b1;
								res_d = esfbc_pkg::make_res(esfbc_pkg::ACT_FREE,
									req.block_handle, req.block_size, 1'b1);
							end else begin
								state_d   = ST_SCAN;
								emp_vld_d = 1'b0;
							end
						end
						esfbc_pkg::REQ_FLUSH: begin
							state_d = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (iss_q < CW'(N)) begin
					cmd.rd_en = 1'b1;
					iss_d     = iss_q + CW'(1);
				end
				if (ev_s1) begin
					case (req_q.req_type)
						esfbc_pkg::REQ_ALLOC: begin
							if (rd_data.size == req_q.block_size && rd_data.handle != 48'd0) begin
								cmd.wr_en = 1'b1;
								res_vld_d = 1'b1;
								res_d = esfbc_pkg::make_res(esfbc_pkg::ACT_HIT, rd_data.handle,
									req_q.block_size, 1'b1);
								state_d = ST_IDLE;
							end else if (last_ent) begin
								res_vld_d = 1'b1;
								res_d = esfbc_pkg::make_res(esfbc_pkg::ACT_FWD, 48'd0,
									req_q.block_size, 1'b1);
								state_d = ST_IDLE;
							end
						end
						esfbc_pkg::REQ_FREE: begin
							if (rd_data.handle == req_q.block_handle) begin
								if (rd_data.size == 32'd0) begin
									cmd.wr_en = 1'b1;
									wr_data   = {req_q.block_size, req_q.block_handle};
								end
								res_vld_d = 1'b1;
								res_d = esfbc_pkg::make_res(esfbc_pkg::ACT_ABSORB,
									req_q.block_handle, req_q.block_size, 1'b1);
								state_d = ST_IDLE;
							end else begin
								if (!emp_vld_q && rd_data.handle == 48'd0) begin
									emp_vld_d = 1'b1;
									emp_idx_d = ptr_s1;
								end
								if (last_ent) begin
									res_vld_d = 1'b1;
									state_d   = ST_IDLE;
									if (emp_vld_d) begin
										cmd.wr_en = 1'b1;
										wr_addr   = emp_idx_d;
										wr_data   = {req_q.block_size, req_q.block_handle};
										res_d = esfbc_pkg::make_res(esfbc_pkg::ACT_ABSORB,
											req_q.block_handle, req_q.block_size, 1'b1);
									end else begin
										res_d = esfbc_pkg::make_res(esfbc_pkg::ACT_FREE,
											req_q.block_handle, req_q.block_size, 1'b1);
									end
								end
							end
						end
						esfbc_pkg::REQ_FLUSH: begin
							if (rd_data.handle != 48'd0) begin
								res_vld_d = 1'b1;
								res_d = esfbc_pkg::make_res(esfbc_pkg::ACT_FREE, rd_data.handle,
									rd_data.size, 1'b0);
							end
							if (last_ent) begin
								state_d = ST_FDONE;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_FDONE: begin
				cmd.clr_all = 1'b1;
				res_vld_d   = 1'b1;
				res_d = esfbc_pkg::make_res(esfbc_pkg::ACT_DONE, 48'd0, 32'd0, 1'b1);
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			iss_q      <= '0;
			ev_s1      <= 1'b0;
			emp_vld_q  <= 1'b0;
			res_strobe <= 1'b0;
		end else begin
			state_q    <= state_d;
			iss_q      <= iss_d;
			ev_s1      <= cmd.rd_en && (state_d == ST_SCAN);
			emp_vld_q  <= emp_vld_d;
			res_strobe <= res_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			req_q <= req;
		end
		if (cmd.rd_en) begin
			ptr_s1 <= rd_addr;
		end
		emp_idx_q <= emp_idx_d;
		res       <= res_d;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ src/exact_size_free_block_cache_top.sv @@
// Exact-size free block cache: alloc, free and flush over a recycled-block table.
// Forwarded requests give their word in the cycle after start; a scanned alloc
// or free ends when an entry matches or after the last entry has been read.
// Flush: one word per held entry, then a done word.
// Throughput is set by the one-read-per-cycle table scan; busy is high meanwhile.
// arst_n clears control, the threshold (to 4194304) and all entry valid bits.
module exact_size_free_block_cache_top #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  esfbc_pkg::req_t req,
	output logic            res_strobe,
	output esfbc_pkg::res_t res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [31:0]     cfg_data
);

	localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	logic [31:0]         thr_q;
	esfbc_pkg::mem_cmd_t cmd;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	esfbc_pkg::entry_t   wr_data;
	esfbc_pkg::entry_t   rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= esfbc_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	esfbc_ctrl #(.N(CACHE_ENTRIES), .AW(AW)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.thr        (thr_q),
		.busy       (busy),
		.res_strobe (res_strobe),
		.res        (res),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_data    (rd_data)
	);

	esfbc_mem #(.N(CACHE_ENTRIES), .AW(AW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

endmodule

@@ src/esfbc_checker.sv @@
// Port-level checks for the free block cache, bound to the top level.
module esfbc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input esfbc_pkg::req_t req,
	input logic            res_strobe,
	input esfbc_pkg::res_t res,
	input logic            cfg_valid,
	input logic            cfg_ready,
	input logic [31:0]     cfg_data
);

	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == esfbc_pkg::REQ_FLUSH) |=> busy)
		else $error("flush not marked busy");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && res.action == esfbc_pkg::ACT_DONE) |-> res.last)
		else $error("flush done without last");

	a_notlast_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && !res.last) |-> (res.action == esfbc_pkg::ACT_FREE && busy))
		else $error("non-final word outside a flush");

	a_null_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && (res.action == esfbc_pkg::ACT_FWD || res.action == esfbc_pkg::ACT_DONE))
		|-> (res.out_handle == 48'd0))
		else $error("handle on forward or done word");

endmodule

bind exact_size_free_block_cache_top esfbc_checker u_esfbc_checker (.*);

@@ tb/exact_size_free_block_cache_checker.sv @@
// Checker for the free block cache: predicts result words and compares them.
module exact_size_free_block_cache_checker
	import esfbc_pkg::*;
#(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  req_t        req,
	input  logic        res_strobe,
	input  res_t        res,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          word_count,
	output int          hit_count,
	output int          done_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] slot_size [CACHE_ENTRIES];
	logic [47:0] slot_handle [CACHE_ENTRIES];
	logic [31:0] threshold;
	res_t        expected_words [$];
	int          fails, words, hits, dones;

	task automatic serve_request(input req_t r);
		int  free_slot;
		bit  found;
		free_slot = -1;
		found = 1'b0;
		case (r.req_type)
			REQ_ALLOC: begin
				if (r.block_size != 0 && r.block_size <= threshold) begin
					for (int i = 0; i < CACHE_ENTRIES; i++) begin
						if (!found && slot_size[i] == r.block_size && slot_handle[i] != 0) begin
							expected_words.push_back(res_t'{ACT_HIT, slot_handle[i],
								r.block_size, 1'b1});
							slot_size[i] = '0;
							slot_handle[i] = '0;
							found = 1'b1;
						end
					end
				end
				if (!found)
					expected_words.push_back(res_t'{ACT_FWD, 48'd0, r.block_size, 1'b1});
			end
			REQ_FREE: begin
				if (r.block_handle == 0 || r.block_size == 0 || r.block_size >= threshold) begin
					expected_words.push_back(res_t'{ACT_FREE, r.block_handle, r.block_size,
						1'b1});
				end else begin
					for (int i = 0; i < CACHE_ENTRIES; i++) begin
						if (!found) begin
							if (slot_handle[i] == r.block_handle) begin
								if (slot_size[i] == 0)
									slot_size[i] = r.block_size;
								found = 1'b1;
							end else if (free_slot < 0 && slot_handle[i] == 0) begin
								free_slot = i;
							end
						end
					end
					if (!found && free_slot >= 0) begin
						slot_handle[free_slot] = r.block_handle;
						slot_size[free_slot] = r.block_size;
						found = 1'b1;
					end
					expected_words.push_back(res_t'{found ? ACT_ABSORB : ACT_FREE,
						r.block_handle, r.block_size, 1'b1});
				end
			end
			REQ_FLUSH: begin
				for (int i = 0; i < CACHE_ENTRIES; i++) begin
					if (slot_handle[i] != 0)
						expected_words.push_back(res_t'{ACT_FREE, slot_handle[i], slot_size[i],
							1'b0});
					slot_size[i] = '0;
					slot_handle[i] = '0;
				end
				expected_words.push_back(res_t'{ACT_DONE, 48'd0, 32'd0, 1'b1});
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_field(input string field, input logic [47:0] want,
			input logic [47:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				slot_size[i] = '0;
				slot_handle[i] = '0;
			end
			threshold = THR_RESET;
			expected_words.delete();
			fails = 0;
			words = 0;
			hits = 0;
			dones = 0;
		end else begin
			if (res_strobe) begin
				words++;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %0h", $time, res);
					fails++;
				end else begin
					want = expected_words.pop_front();
					compare_field("action", 48'(want.action), 48'(res.action));
					compare_field("out_handle", want.out_handle, res.out_handle);
					compare_field("out_size", 48'(want.out_size), 48'(res.out_size));
					compare_field("last", 48'(want.last), 48'(res.last));
					if (res.action == ACT_HIT)
						hits++;
					if (res.action == ACT_DONE)
						dones++;
				end
			end
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;
			if (start && !busy)
				serve_request(req);
		end
		fail_count <= fails;
		pending    <= expected_words.size();
		word_count <= words;
		hit_count  <= hits;
		done_count <= dones;
	end

endmodule

@@ tb/exact_size_free_block_cache_top_test.sv @@
// Testbench top for the free block cache: stimulus, configuration and verdict.
module exact_size_free_block_cache_top_test;
	import esfbc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CACHE_ENTRIES = 16;
	localparam int         PHASE_ITEMS   = 72;
	localparam logic [1:0] REQ_NONE      = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        res_strobe;
	res_t        res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	int          fail_count, pending, word_count, hit_count, done_count;
	bit          calm;

	always #1 clk = ~clk;

	exact_size_free_block_cache_top #(
		.CACHE_ENTRIES(CACHE_ENTRIES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.res_strobe(res_strobe),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	exact_size_free_block_cache_checker #(
		.CACHE_ENTRIES(CACHE_ENTRIES)
	) i_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.res_strobe(res_strobe),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending),
		.word_count(word_count),
		.hit_count (hit_count),
		.done_count(done_count)
	);

	task automatic issue(input logic [1:0] kind, input logic [31:0] sz, input logic [47:0] h);
		if (!calm && $urandom_range(0, 99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= req_t'{kind, sz, h};
		do @(posedge clk); while (busy);
	endtask

	// hold off until every expected word is back, then cover trailing work
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (CACHE_ENTRIES + 4) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] thr_list [6];
		logic [1:0]  kind;
		logic [31:0] sz;
		logic [47:0] h;
		int          pick, sent, total;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		calm      = 1'b0;
		total     = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: forwarding rules, duplicate free, hit, full table, flushes
		issue(REQ_ALLOC, 32'd0, 48'd5);
		issue(REQ_ALLOC, 32'd64, 48'd0);
		issue(REQ_FREE, 32'd64, 48'd0);
		issue(REQ_FREE, 32'd0, 48'd1);
		issue(REQ_FREE, THR_RESET, 48'd2);
		issue(REQ_FREE, 32'd64, 48'd3);
		issue(REQ_FREE, 32'd128, 48'd3);
		issue(REQ_ALLOC, 32'd64, 48'd0);
		issue(REQ_ALLOC, 32'd64, 48'd0);
		issue(REQ_ALLOC, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		issue(REQ_NONE, 32'd64, 48'd7);
		issue(REQ_FREE, THR_RESET - 1, 48'hFFFF_FFFF_FFFF);
		for (int i = 1; i < CACHE_ENTRIES; i++)
			issue(REQ_FREE, 32'(i), 48'(i + 16));
		issue(REQ_FREE, 32'd9, 48'd99);
		issue(REQ_ALLOC, THR_RESET - 1, 48'd0);
		issue(REQ_FLUSH, 32'd0, 48'd0);
		issue(REQ_FLUSH, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		total += 5 + CACHE_ENTRIES + 9;
		drain();

		thr_list = '{THR_RESET, 32'hFFFF_FFFF, 32'd16, 32'd0,
			32'($urandom_range(1, 4096)), THR_RESET};
		for (int p = 0; p < 6; p++) begin
			if (p != 0)
				set_threshold(thr_list[p]);
			calm = (p == 1);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				kind = pick < 46 ? REQ_ALLOC : pick < 92 ? REQ_FREE :
					pick < 97 ? REQ_FLUSH : REQ_NONE;
				sz = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 8));
				h = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) :
					48'($urandom_range(0, 24));
				issue(kind, sz, h);
				if (kind != REQ_NONE)
					sent++;
			end
			total += sent;
			drain();
		end

		$display("Covered %0d requests over six threshold settings, zero and all ones among them.",
			total);
		$display("Checked %0d result words: %0d alloc hits, %0d completed flushes.",
			word_count, hit_count, done_count);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ exact_size_free_block_cache_top.f @@
src/esfbc_pkg.sv
src/esfbc_mem.sv
src/esfbc_ctrl.sv
src/exact_size_free_block_cache_top.sv
src/esfbc_checker.sv
tb/exact_size_free_block_cache_checker.sv
tb/exact_size_free_block_cache_top_test.sv
